// ===== sv/ffha_pkg.sv =====
// Shared types, constants and helpers of the first-fit heap allocator.
package ffha_pkg;

    localparam int ARENA_BYTES  = 65536;
    localparam int HEADER_BYTES = 32;
    localparam int WORD_BYTES   = 8;
    localparam int WORD_SHIFT   = 3;
    localparam int ARENA_WORDS  = ARENA_BYTES / WORD_BYTES;
    localparam int HDR_WORDS    = (HEADER_BYTES + WORD_BYTES - 1) / WORD_BYTES;
    localparam int ADDR_W       = 13;
    localparam int SIZE_W       = 13;
    localparam int TOP_W        = 14;
    localparam int PTR_W        = 15;
    localparam int WORDS_W      = 22;
    localparam int THR_W        = 24;
    localparam int UADDR_W      = 16;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_ZERO      = 2'd1;
    localparam logic [1:0] ST_TOO_LARGE = 2'd2;
    localparam logic [1:0] ST_NO_SPACE  = 2'd3;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    typedef struct packed {
        logic              mark;
        logic              free;
        logic [SIZE_W-1:0] size;
    } entry_t;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        entry_t            data;
    } mem_wr_t;

    // Byte offset of the user data of the block whose header starts at word p
    function automatic logic [UADDR_W-1:0] user_of(input logic [PTR_W-1:0] p);
        logic [ADDR_W-1:0] w;
        w = p[ADDR_W-1:0] + ADDR_W'(HDR_WORDS);
        return {w, 3'b000};
    endfunction

endpackage

// ===== sv/ffha_mem.sv =====
// Block header store: size, free flag and start mark per arena word.
module ffha_mem (
    input  logic                     clk,
    input  ffha_pkg::mem_wr_t        wr,
    input  logic [ffha_pkg::ADDR_W-1:0] raddr,
    output ffha_pkg::entry_t         rdata
);
    import ffha_pkg::*;

    entry_t mem [ARENA_WORDS];

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

// ===== sv/ffha_ctrl.sv =====
// Sequencer: header walks, split, append, merge and the result register.
module ffha_ctrl (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [ffha_pkg::THR_W-1:0]  threshold,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic                        in_op,
    input  logic [23:0]                 in_req,
    input  logic [15:0]                 in_faddr,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [1:0]                  out_status,
    output logic [ffha_pkg::UADDR_W-1:0] out_addr,
    output ffha_pkg::mem_wr_t           wr,
    output logic [ffha_pkg::ADDR_W-1:0] raddr,
    input  ffha_pkg::entry_t            rdata
);
    import ffha_pkg::*;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_A_RD, S_A_EV, S_A_SPLIT,
        S_F_RD, S_F_EV, S_F_NEV, S_F_WP,
        S_P_RD, S_P_EV, S_P_WM, S_DONE
    } state_t;

    state_t             state_reg, state_next;
    logic [PTR_W-1:0]   p_reg, p_next;
    logic [PTR_W-1:0]   q_reg, q_next;
    logic [WORDS_W-1:0] words_reg, words_next;
    logic [SIZE_W-1:0]  sz_reg, sz_next;
    logic [TOP_W-1:0]   top_reg, top_next;
    logic [1:0]         rs_reg, rs_next;
    logic [UADDR_W-1:0] ra_reg, ra_next;
    logic               ov_reg, ov_next;
    logic [1:0]         os_reg, os_next;
    logic [UADDR_W-1:0] oa_reg, oa_next;
    logic [ADDR_W-1:0]  clr_reg, clr_next;

    logic [WORDS_W-1:0] req_words;
    logic [24:0]        req_round;
    logic [ADDR_W-1:0]  fw;
    logic [TOP_W-1:0]   fp;
    logic               f_ok;
    logic [PTR_W-1:0]   nxt_p;
    logic [PTR_W-1:0]   nxt_q;
    logic [22:0]        app_end;

    always_comb
    begin
        req_words = WORDS_W'((25'(in_req) + 25'd7) >> WORD_SHIFT);
        req_round = {req_words, 3'b000};
        fw        = in_faddr[15:3];
        fp        = TOP_W'(fw) - TOP_W'(HDR_WORDS);
        f_ok      = (in_faddr[2:0] == 3'b000) && (fw >= ADDR_W'(HDR_WORDS)) && (fp < top_reg);
        nxt_p     = p_reg + PTR_W'(HDR_WORDS) + PTR_W'(rdata.size);
        nxt_q     = q_reg + PTR_W'(HDR_WORDS) + PTR_W'(rdata.size);
        app_end   = 23'(top_reg) + 23'(HDR_WORDS) + 23'(words_reg);
    end

    always_comb
    begin
        state_next = state_reg;
        p_next     = p_reg;
        q_next     = q_reg;
        words_next = words_reg;
        sz_next    = sz_reg;
        top_next   = top_reg;
        rs_next    = rs_reg;
        ra_next    = ra_reg;
        ov_next    = ov_reg;
        os_next    = os_reg;
        oa_next    = oa_reg;
        clr_next   = clr_reg;
        wr         = '0;
        raddr      = p_reg[ADDR_W-1:0];
        in_ready   = (state_reg == S_IDLE);

        if (ov_reg && out_ready)
        begin
            ov_next = 1'b0;
        end

        unique case (state_reg)
            S_CLEAR:
            begin
                wr.en    = 1'b1;
                wr.addr  = clr_reg;
                clr_next = clr_reg + ADDR_W'(1);
                if (clr_reg == ADDR_W'(ARENA_WORDS - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    rs_next = ST_OK;
                    ra_next = '0;
                    if (in_op == OP_ALLOC)
                    begin
                        words_next = req_words;
                        p_next     = '0;
                        if (in_req == 24'd0)
                        begin
                            rs_next    = ST_ZERO;
                            state_next = S_DONE;
                        end
                        else if (req_round >= 25'(threshold))
                        begin
                            rs_next    = ST_TOO_LARGE;
                            state_next = S_DONE;
                        end
                        else
                        begin
                            state_next = S_A_RD;
                        end
                    end
                    else
                    begin
                        p_next     = PTR_W'(fp);
                        state_next = f_ok ? S_F_RD : S_DONE;
                    end
                end
            end
            S_A_RD:
            begin
                if (p_reg < PTR_W'(top_reg))
                begin
                    state_next = S_A_EV;
                end
                else if (app_end > 23'(ARENA_WORDS))
                begin
                    rs_next    = ST_NO_SPACE;
                    state_next = S_DONE;
                end
                else
                begin
                    // append a new block at the heap top
                    wr.en      = 1'b1;
                    wr.addr    = top_reg[ADDR_W-1:0];
                    wr.data    = '{mark: 1'b1, free: 1'b0, size: words_reg[SIZE_W-1:0]};
                    top_next   = app_end[TOP_W-1:0];
                    ra_next    = user_of(PTR_W'(top_reg));
                    state_next = S_DONE;
                end
            end
            S_A_EV:
            begin
                if (rdata.free && (WORDS_W'(rdata.size) >= words_reg))
                begin
                    ra_next = user_of(p_reg);
                    wr.en   = 1'b1;
                    if (23'(rdata.size) >= 23'(words_reg) + 23'(HDR_WORDS + 1))
                    begin
                        // tail becomes a free block of its own
                        wr.addr    = p_reg[ADDR_W-1:0] + ADDR_W'(HDR_WORDS)
                                     + words_reg[ADDR_W-1:0];
                        wr.data    = '{mark: 1'b1, free: 1'b1,
                                       size: rdata.size - words_reg[SIZE_W-1:0]
                                             - SIZE_W'(HDR_WORDS)};
                        state_next = S_A_SPLIT;
                    end
                    else
                    begin
                        wr.addr    = p_reg[ADDR_W-1:0];
                        wr.data    = '{mark: 1'b1, free: 1'b0, size: rdata.size};
                        state_next = S_DONE;
                    end
                end
                else
                begin
                    p_next     = nxt_p;
                    state_next = S_A_RD;
                end
            end
            S_A_SPLIT:
            begin
                wr.en      = 1'b1;
                wr.addr    = p_reg[ADDR_W-1:0];
                wr.data    = '{mark: 1'b1, free: 1'b0, size: words_reg[SIZE_W-1:0]};
                state_next = S_DONE;
            end
            S_F_RD:
            begin
                state_next = S_F_EV;
            end
            S_F_EV:
            begin
                sz_next = rdata.size;
                if (!rdata.mark)
                begin
                    state_next = S_DONE;
                end
                else if (nxt_p < PTR_W'(top_reg))
                begin
                    raddr      = nxt_p[ADDR_W-1:0];
                    q_next     = nxt_p;
                    state_next = S_F_NEV;
                end
                else
                begin
                    state_next = S_F_WP;
                end
            end
            S_F_NEV:
            begin
                if (rdata.mark && rdata.free)
                begin
                    sz_next = sz_reg + SIZE_W'(HDR_WORDS) + rdata.size;
                    wr.en   = 1'b1;
                    wr.addr = q_reg[ADDR_W-1:0];
                    wr.data = '{mark: 1'b0, free: rdata.free, size: rdata.size};
                end
                state_next = S_F_WP;
            end
            S_F_WP:
            begin
                wr.en      = 1'b1;
                wr.addr    = p_reg[ADDR_W-1:0];
                wr.data    = '{mark: 1'b1, free: 1'b1, size: sz_reg};
                q_next     = '0;
                state_next = S_P_RD;
            end
            S_P_RD:
            begin
                raddr = q_reg[ADDR_W-1:0];
                state_next = (q_reg < p_reg) ? S_P_EV : S_DONE;
            end
            S_P_EV:
            begin
                raddr = q_reg[ADDR_W-1:0];
                if (nxt_q == p_reg)
                begin
                    if (rdata.free)
                    begin
                        wr.en      = 1'b1;
                        wr.addr    = q_reg[ADDR_W-1:0];
                        wr.data    = '{mark: rdata.mark, free: 1'b1,
                                       size: rdata.size + SIZE_W'(HDR_WORDS) + sz_reg};
                        state_next = S_P_WM;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
                else
                begin
                    q_next     = nxt_q;
                    state_next = S_P_RD;
                end
            end
            S_P_WM:
            begin
                wr.en      = 1'b1;
                wr.addr    = p_reg[ADDR_W-1:0];
                wr.data    = '{mark: 1'b0, free: 1'b1, size: sz_reg};
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!ov_reg || out_ready)
                begin
                    ov_next    = 1'b1;
                    os_next    = rs_reg;
                    oa_next    = ra_reg;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            top_reg   <= '0;
            ov_reg    <= 1'b0;
            clr_reg   <= '0;
            p_reg     <= '0;
            q_reg     <= '0;
            words_reg <= '0;
            sz_reg    <= '0;
            rs_reg    <= '0;
            ra_reg    <= '0;
            os_reg    <= '0;
            oa_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            top_reg   <= top_next;
            ov_reg    <= ov_next;
            clr_reg   <= clr_next;
            p_reg     <= p_next;
            q_reg     <= q_next;
            words_reg <= words_next;
            sz_reg    <= sz_next;
            rs_reg    <= rs_next;
            ra_reg    <= ra_next;
            os_reg    <= os_next;
            oa_reg    <= oa_next;
        end
    end

    assign out_valid  = ov_reg;
    assign out_status = os_reg;
    assign out_addr   = oa_reg;

`ifndef NO_ASSERTIONS
    a_top_in_arena: assert property (@(posedge clk) disable iff (!rst_n)
        top_reg <= TOP_W'(ARENA_WORDS))
        else $error("heap top past arena end");

    a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> !wr.en)
        else $error("header write while idle");

    a_top_only_append: assert property (@(posedge clk) disable iff (!rst_n)
        (top_reg != $past(top_reg)) |-> ($past(state_reg) == S_A_RD))
        else $error("heap top moved outside append");
`endif

endmodule

// ===== sv/first_fit_heap_allocator.sv =====
// Top level of the first-fit heap allocator: threshold register, sequencer and header store.
//
// channel   dir  handshake                       payload
// s_axis    in   s_axis_tvalid / s_axis_tready   tdata {free_addr, req_bytes}, tuser operation
// m_axis    out  m_axis_tvalid / m_axis_tready   tdata {user_addr, status}
// cfg       in   cfg_we                          cfg_wdata large_threshold
//
// A refused request or a bad free address goes straight to the result load; an allocate
// walks the block headers, then appends, fits or fits with a split; a free merges a free
// next block into the freed one and rewrites its header, then walks the headers below it
// to merge into a free previous block. After reset a clearing pass sweeps the header store;
// no transfer is taken meanwhile. The result register lets the next item start while a
// result waits; a finished item stalls only while that register holds an unaccepted result.
module first_fit_heap_allocator (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // req_bytes[23:0], free_addr[39:24]
    input  logic        s_axis_tuser,   // operation
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // status[1:0], user_addr[17:2], zero[23:18]
    input  logic        cfg_we,
    input  logic [23:0] cfg_wdata
);
    import ffha_pkg::*;

    logic [THR_W-1:0]   thr_reg;
    mem_wr_t            wr;
    logic [ADDR_W-1:0]  raddr;
    entry_t             rdata;
    logic [1:0]         status;
    logic [UADDR_W-1:0] user_addr;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= THR_W'(131072);
        end
        else if (cfg_we)
        begin
            thr_reg <= cfg_wdata;
        end
    end

    ffha_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .threshold  (thr_reg),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_op      (s_axis_tuser),
        .in_req     (s_axis_tdata[23:0]),
        .in_faddr   (s_axis_tdata[39:24]),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_status (status),
        .out_addr   (user_addr),
        .wr         (wr),
        .raddr      (raddr),
        .rdata      (rdata)
    );

    ffha_mem u_mem (
        .clk   (clk),
        .wr    (wr),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign m_axis_tdata = {6'd0, user_addr, status};

endmodule
